// ----- sv/sym2dwt_pkg.sv -----
// Shared types and constants for the symlet-2 line analysis filter bank.
// Used by sym2dwt_mac, sym2_dwt_analysis_line and the scoreboard; depends on nothing else.
package sym2dwt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int OUT_BITS    = SAMPLE_BITS + 2;
    localparam int NUM_TAPS    = 4;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;

    // Line position: counts up to the first pair, then alternates even and odd samples.
    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_PAIR  = 3'd2;
    localparam logic [2:0] POS_THIRD = 3'd3;
    localparam logic [2:0] POS_EVEN  = 3'd4;
    localparam logic [2:0] POS_ODD   = 3'd5;

    // One filter evaluation: the sample that meets each tap, after mirroring.
    typedef struct packed {
        logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] smp;
        logic                                 line_done;
        logic                                 short_line;
    } job_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] low_value;
        logic [OUT_BITS-1:0] high_value;
        logic                line_done;
        logic                short_line;
    } result_t;

endpackage

// ----- sv/sym2dwt_mac.sv -----
// Multiply-accumulate unit: eight products per item, registered, then the
// rounded sums into the result register. Depends on sym2dwt_pkg.
module sym2dwt_mac (
    input  logic                                                         clk,
    input  logic                                                         rst_n,
    input  logic                                                         en,
    input  logic                                                         issue_valid,
    input  sym2dwt_pkg::job_t                                            issue_job,
    input  logic [sym2dwt_pkg::NUM_TAPS-1:0][sym2dwt_pkg::COEF_BITS-1:0] low_taps,
    input  logic [sym2dwt_pkg::NUM_TAPS-1:0][sym2dwt_pkg::COEF_BITS-1:0] high_taps,
    output logic                                                         res_valid,
    output sym2dwt_pkg::result_t                                         res
);

    localparam logic signed [sym2dwt_pkg::ACC_BITS-1:0] ROUND_HALF =
        sym2dwt_pkg::ACC_BITS'(1) <<< (sym2dwt_pkg::COEF_BITS - 2);

    logic signed [sym2dwt_pkg::PROD_BITS-1:0] lo_prod_reg  [sym2dwt_pkg::NUM_TAPS];
    logic signed [sym2dwt_pkg::PROD_BITS-1:0] hi_prod_reg  [sym2dwt_pkg::NUM_TAPS];
    logic signed [sym2dwt_pkg::PROD_BITS-1:0] lo_prod_next [sym2dwt_pkg::NUM_TAPS];
    logic signed [sym2dwt_pkg::PROD_BITS-1:0] hi_prod_next [sym2dwt_pkg::NUM_TAPS];
    logic                                     prod_valid_reg;
    logic                                     prod_done_reg;
    logic                                     prod_short_reg;
    logic signed [sym2dwt_pkg::ACC_BITS-1:0]  lo_acc;
    logic signed [sym2dwt_pkg::ACC_BITS-1:0]  hi_acc;
    logic                                     res_valid_reg;
    sym2dwt_pkg::result_t                     res_reg;
    sym2dwt_pkg::result_t                     res_next;

    always_comb
    begin
        for (int w = 0; w < sym2dwt_pkg::NUM_TAPS; w++)
        begin
            lo_prod_next[w] = sym2dwt_pkg::PROD_BITS'($signed(issue_job.smp[w])
                                                      * $signed(low_taps[w]));
            hi_prod_next[w] = sym2dwt_pkg::PROD_BITS'($signed(issue_job.smp[w])
                                                      * $signed(high_taps[w]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int w = 0; w < sym2dwt_pkg::NUM_TAPS; w++)
            begin
                lo_prod_reg[w] <= lo_prod_next[w];
                hi_prod_reg[w] <= hi_prod_next[w];
            end
            prod_done_reg  <= issue_job.line_done;
            prod_short_reg <= issue_job.short_line;
            res_reg        <= res_next;
        end
    end

    // Round half up, then floor-shift; the top bits are dropped, so large
    // sums wrap.
    always_comb
    begin
        lo_acc = ROUND_HALF;
        hi_acc = ROUND_HALF;
        for (int w = 0; w < sym2dwt_pkg::NUM_TAPS; w++)
        begin
            lo_acc = lo_acc + sym2dwt_pkg::ACC_BITS'(lo_prod_reg[w]);
            hi_acc = hi_acc + sym2dwt_pkg::ACC_BITS'(hi_prod_reg[w]);
        end
        res_next.low_value  = lo_acc[sym2dwt_pkg::COEF_BITS-1 +: sym2dwt_pkg::OUT_BITS];
        res_next.high_value = hi_acc[sym2dwt_pkg::COEF_BITS-1 +: sym2dwt_pkg::OUT_BITS];
        res_next.line_done  = prod_done_reg;
        res_next.short_line = prod_short_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= issue_valid;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- sv/sym2_dwt_analysis_line.sv -----
// Symlet-2 analysis filter bank for one line of samples: mirrored edges,
// Q1.15 taps, rounded 18-bit low/high results. Depends on sym2dwt_pkg, sym2dwt_mac.
// A result pair passes the job register, the product register and the result register.
// Throughput: one sample per cycle while the output is not stalled, except that a sample
// that yields two pairs makes the next sample wait until the first pair enters the single multiply stage.
// Reset clears the pipeline, the line position and the sample history, and
// loads the default symlet-2 taps.
module sym2_dwt_analysis_line (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [17:0] low_value, [35:18] high_value, [39:36] zero
    output logic        m_tlast,   // line_done
    output logic        m_tuser,   // short_line
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NUM_REGS  = 2 * sym2dwt_pkg::NUM_TAPS;
    localparam int ADDR_BITS = $clog2(NUM_REGS) + 2;
    localparam int APB_BITS  = 32;
    localparam int OUT_TDATA = ((2 * sym2dwt_pkg::OUT_BITS + 7) / 8) * 8;

    localparam logic [NUM_REGS-1:0][sym2dwt_pkg::COEF_BITS-1:0] COEF_RESET = {
        sym2dwt_pkg::COEF_BITS'(-4240),  sym2dwt_pkg::COEF_BITS'(-7345),
        sym2dwt_pkg::COEF_BITS'(27411),  sym2dwt_pkg::COEF_BITS'(-15826),
        sym2dwt_pkg::COEF_BITS'(15826),  sym2dwt_pkg::COEF_BITS'(27411),
        sym2dwt_pkg::COEF_BITS'(7345),   sym2dwt_pkg::COEF_BITS'(-4240)
    };

    typedef logic [sym2dwt_pkg::SAMPLE_BITS-1:0] smp_t;

    logic [NUM_REGS-1:0][sym2dwt_pkg::COEF_BITS-1:0] coef_reg;
    logic [$clog2(NUM_REGS)-1:0]                     reg_index;
    logic                                            cfg_write;

    smp_t                 hist_reg [3];
    logic [2:0]           pos_reg;
    logic [2:0]           pos_next;
    sym2dwt_pkg::job_t    job0_reg;
    sym2dwt_pkg::job_t    job1_reg;
    logic [1:0]           count_reg;
    sym2dwt_pkg::job_t    new_job0;
    sym2dwt_pkg::job_t    new_job1;
    logic [1:0]           new_count;
    logic                 accept;
    logic                 en;
    logic                 issue;
    smp_t                 smp_in;
    logic                 res_valid;
    sym2dwt_pkg::result_t res;

    // Samples for each tap, oldest first in the concatenation: tap 3 .. tap 0.
    function automatic sym2dwt_pkg::job_t make_job(smp_t t3, smp_t t2, smp_t t1,
                                                   smp_t t0, logic done);
        sym2dwt_pkg::job_t j;
        j.smp        = {t3, t2, t1, t0};
        j.line_done  = done;
        j.short_line = 1'b0;
        return j;
    endfunction

    // ---------------- configuration ----------------
    assign reg_index = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = {{(APB_BITS - sym2dwt_pkg::COEF_BITS)
                          {coef_reg[reg_index][sym2dwt_pkg::COEF_BITS-1]}},
                        coef_reg[reg_index]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else if (cfg_write)
        begin
            coef_reg[reg_index] <= pwdata[sym2dwt_pkg::COEF_BITS-1:0];
        end
    end

    // ---------------- job generation ----------------
    assign smp_in = s_tdata[sym2dwt_pkg::SAMPLE_BITS-1:0];

    // Window: smp_in is the newest sample, hist_reg[0..2] the three before it.
    // Edge pairs read mirrored positions, so some samples meet two taps.
    always_comb
    begin
        new_job0  = '0;
        new_job1  = '0;
        new_count = 2'd0;
        if (s_tlast && pos_reg <= sym2dwt_pkg::POS_PAIR)
        begin
            new_job0.line_done  = 1'b1;
            new_job0.short_line = 1'b1;
            new_count           = 2'd1;
        end
        else if (pos_reg == sym2dwt_pkg::POS_PAIR)
        begin
            new_job0  = make_job(smp_in, hist_reg[0], hist_reg[1], hist_reg[1], 1'b0);
            new_job1  = make_job(hist_reg[1], hist_reg[1], hist_reg[0], smp_in, 1'b0);
            new_count = 2'd2;
        end
        else if ((pos_reg == sym2dwt_pkg::POS_THIRD || pos_reg == sym2dwt_pkg::POS_ODD)
                 && s_tlast)
        begin
            new_job0  = make_job(hist_reg[1], hist_reg[0], smp_in, smp_in, 1'b0);
            new_job1  = make_job(smp_in, smp_in, hist_reg[0], hist_reg[1], 1'b1);
            new_count = 2'd2;
        end
        else if (pos_reg == sym2dwt_pkg::POS_EVEN)
        begin
            new_job0  = make_job(hist_reg[2], hist_reg[1], hist_reg[0], smp_in, 1'b0);
            new_job1  = make_job(hist_reg[0], smp_in, smp_in, hist_reg[0], 1'b1);
            new_count = s_tlast ? 2'd2 : 2'd1;
        end
    end

    always_comb
    begin
        if (s_tlast)
        begin
            pos_next = sym2dwt_pkg::POS_START;
        end
        else if (pos_reg >= sym2dwt_pkg::POS_ODD)
        begin
            pos_next = sym2dwt_pkg::POS_EVEN;
        end
        else
        begin
            pos_next = pos_reg + 3'd1;
        end
    end

    // ---------------- pending jobs and handshake ----------------
    assign en       = !res_valid || m_tready;
    assign issue    = en && (count_reg != 2'd0);
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && en);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= sym2dwt_pkg::POS_START;
            count_reg   <= 2'd0;
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg     <= pos_next;
                count_reg   <= new_count;
                hist_reg[0] <= smp_in;
                hist_reg[1] <= hist_reg[0];
                hist_reg[2] <= hist_reg[1];
            end
            else if (issue)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job0_reg <= new_job0;
            job1_reg <= new_job1;
        end
        else if (issue)
        begin
            job0_reg <= job1_reg;
        end
    end

    sym2dwt_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .issue_valid (issue),
        .issue_job   (job0_reg),
        .low_taps    (coef_reg[sym2dwt_pkg::NUM_TAPS-1:0]),
        .high_taps   (coef_reg[NUM_REGS-1:sym2dwt_pkg::NUM_TAPS]),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = OUT_TDATA'({res.high_value, res.low_value});
    assign m_tlast  = res.line_done;
    assign m_tuser  = res.short_line;

    // ---------------- assertions ----------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("pending job count out of range");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !s_tready)
        else $error("input taken while two jobs are pending");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> pos_reg == sym2dwt_pkg::POS_START)
        else $error("line position not cleared after the last sample");

    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("short-line result must be final and zero");

endmodule

// ----- tb/sv/sym2_dwt_scoreboard.sv -----
// Scoreboard for the symlet-2 line analysis filter bank: tracks tap writes on
// the APB port, predicts every low/high result pair and compares it.
// Depends on sym2dwt_pkg.
`timescale 1ns / 1ps

module sym2_dwt_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic        s_tlast,   // line_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [17:0] low_value, [35:18] high_value, [39:36] zero
    input  logic        m_tlast,   // line_done
    input  logic        m_tuser,   // short_line
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending_pairs,
    output int          pairs_seen,
    output int          short_seen
);

    logic signed [sym2dwt_pkg::COEF_BITS-1:0]   low_taps [sym2dwt_pkg::NUM_TAPS];
    logic signed [sym2dwt_pkg::COEF_BITS-1:0]   high_taps [sym2dwt_pkg::NUM_TAPS];
    logic signed [sym2dwt_pkg::SAMPLE_BITS-1:0] history [sym2dwt_pkg::NUM_TAPS-1];
    logic signed [sym2dwt_pkg::SAMPLE_BITS-1:0] window [sym2dwt_pkg::NUM_TAPS];
    logic [2:0]                                 line_phase;
    sym2dwt_pkg::result_t                       expected_pairs [$];

    function automatic logic [sym2dwt_pkg::OUT_BITS-1:0] round_q15(input longint acc);
        longint q;
        q = (acc + (longint'(1) << (sym2dwt_pkg::COEF_BITS - 2)))
            >>> (sym2dwt_pkg::COEF_BITS - 1);
        return q[sym2dwt_pkg::OUT_BITS-1:0];
    endfunction

    // r is the output position minus the current sample index; the mirror
    // folds apply only at the start and at the end of the line.
    function automatic sym2dwt_pkg::result_t filter_pair(input int r, input bit at_start,
                                                         input bit at_end, input bit done);
        sym2dwt_pkg::result_t pair;
        longint               low_acc;
        longint               high_acc;
        int                   d;
        int                   back;
        low_acc  = 0;
        high_acc = 0;
        for (int w = 0; w < sym2dwt_pkg::NUM_TAPS; w++)
        begin
            d = r - w;
            if (at_start && d + 2 < 0)
                d = -d - 5;
            if (at_end && d >= 1)
                d = 1 - d;
            back = (-d) & 3;
            low_acc  += longint'(low_taps[w]) * longint'(window[back]);
            high_acc += longint'(high_taps[w]) * longint'(window[back]);
        end
        pair.low_value  = round_q15(low_acc);
        pair.high_value = round_q15(high_acc);
        pair.line_done  = done;
        pair.short_line = 1'b0;
        return pair;
    endfunction

    task automatic check_field(input string name,
                               input logic signed [sym2dwt_pkg::OUT_BITS-1:0] want,
                               input logic signed [sym2dwt_pkg::OUT_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        sym2dwt_pkg::result_t got;
        sym2dwt_pkg::result_t want;
        sym2dwt_pkg::result_t pair;
        logic [2:0]           phase;
        logic                 last;
        if (!rst_n)
        begin
            low_taps[0]  = -16'sd4240;
            low_taps[1]  = 16'sd7345;
            low_taps[2]  = 16'sd27411;
            low_taps[3]  = 16'sd15826;
            high_taps[0] = -16'sd15826;
            high_taps[1] = 16'sd27411;
            high_taps[2] = -16'sd7345;
            high_taps[3] = -16'sd4240;
            for (int i = 0; i < sym2dwt_pkg::NUM_TAPS - 1; i++)
                history[i] = '0;
            line_phase = sym2dwt_pkg::POS_START;
            expected_pairs.delete();
            mismatches = 0;
            pairs_seen = 0;
            short_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[4:2] < sym2dwt_pkg::NUM_TAPS)
                    low_taps[paddr[4:2]] = pwdata[sym2dwt_pkg::COEF_BITS-1:0];
                else
                    high_taps[paddr[4:2] - sym2dwt_pkg::NUM_TAPS] =
                        pwdata[sym2dwt_pkg::COEF_BITS-1:0];
            end

            if (m_tvalid && m_tready)
            begin
                got.low_value  = m_tdata[sym2dwt_pkg::OUT_BITS-1:0];
                got.high_value = m_tdata[2*sym2dwt_pkg::OUT_BITS-1:sym2dwt_pkg::OUT_BITS];
                got.line_done  = m_tlast;
                got.short_line = m_tuser;
                pairs_seen++;
                if (m_tuser)
                    short_seen++;
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got low %0d high %0d",
                             $time, $signed(got.low_value), $signed(got.high_value));
                    mismatches++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    check_field("low_value", want.low_value, got.low_value);
                    check_field("high_value", want.high_value, got.high_value);
                    check_field("line_done", sym2dwt_pkg::OUT_BITS'(want.line_done),
                                sym2dwt_pkg::OUT_BITS'(got.line_done));
                    check_field("short_line", sym2dwt_pkg::OUT_BITS'(want.short_line),
                                sym2dwt_pkg::OUT_BITS'(got.short_line));
                    check_field("tdata padding", '0,
                                sym2dwt_pkg::OUT_BITS'(m_tdata[39:2*sym2dwt_pkg::OUT_BITS]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                phase     = line_phase;
                last      = s_tlast;
                window[0] = s_tdata;
                for (int i = 1; i < sym2dwt_pkg::NUM_TAPS; i++)
                    window[i] = history[i-1];

                if (last && phase <= sym2dwt_pkg::POS_PAIR)
                begin
                    // Short line: one flagged result with both values zero.
                    pair.low_value  = '0;
                    pair.high_value = '0;
                    pair.line_done  = 1'b1;
                    pair.short_line = 1'b1;
                    expected_pairs.push_back(pair);
                end
                else if (phase == sym2dwt_pkg::POS_PAIR)
                begin
                    expected_pairs.push_back(filter_pair(-2, 1'b1, 1'b0, 1'b0));
                    expected_pairs.push_back(filter_pair(0, 1'b1, 1'b0, 1'b0));
                end
                else if (phase == sym2dwt_pkg::POS_THIRD || phase == sym2dwt_pkg::POS_ODD)
                begin
                    if (last)
                    begin
                        expected_pairs.push_back(filter_pair(1, 1'b0, 1'b1, 1'b0));
                        expected_pairs.push_back(filter_pair(3, 1'b0, 1'b1, 1'b1));
                    end
                end
                else if (phase == sym2dwt_pkg::POS_EVEN)
                begin
                    expected_pairs.push_back(filter_pair(0, 1'b0, last, 1'b0));
                    if (last)
                        expected_pairs.push_back(filter_pair(2, 1'b0, 1'b1, 1'b1));
                end

                for (int i = sym2dwt_pkg::NUM_TAPS - 2; i > 0; i--)
                    history[i] = history[i-1];
                history[0] = window[0];

                if (last)
                    line_phase = sym2dwt_pkg::POS_START;
                else if (phase >= sym2dwt_pkg::POS_ODD)
                    line_phase = sym2dwt_pkg::POS_EVEN;
                else
                    line_phase = phase + 3'd1;
            end
        end
        pending_pairs = expected_pairs.size();
    end

endmodule

// ----- tb/sv/tb_sym2_dwt_analysis_line.sv -----
// Top of the testbench for sym2_dwt_analysis_line: clock, reset, sample and
// tap-register stimulus, output back-pressure and the verdict.
// Depends on sym2dwt_pkg, the block itself and sym2_dwt_scoreboard.
`timescale 1ns / 1ps

module tb_sym2_dwt_analysis_line;

    localparam int IDLE_PCT      = 7;
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int NUM_PHASES    = 6;

    localparam logic [15:0] MAX_VAL = 16'h7FFF;
    localparam logic [15:0] MIN_VAL = 16'h8000;

    typedef enum logic [2:0] {
        REG_LOW_TAP0,
        REG_LOW_TAP1,
        REG_LOW_TAP2,
        REG_LOW_TAP3,
        REG_HIGH_TAP0,
        REG_HIGH_TAP1,
        REG_HIGH_TAP2,
        REG_HIGH_TAP3
    } tap_reg_e;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] sample
    logic        s_tlast  = 1'b0; // line_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [17:0] low_value, [35:18] high_value, [39:36] zero
    logic        m_tlast;         // line_done
    logic        m_tuser;         // short_line
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending_pairs;
    int pairs_seen;
    int short_seen;
    int items_sent   = 0;
    int lines_sent   = 0;
    int stall_cycles = 0;
    bit steady       = 1'b0;
    bit hold_pending = 1'b0;

    sym2_dwt_analysis_line u_dut (.*);

    sym2_dwt_scoreboard u_scoreboard (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                m_tready <= 1'b0;
                hold_pending = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic write_tap(input tap_reg_e idx, input logic [15:0] value);
        logic ok;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{value[15]}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end
        while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_taps(input logic [15:0] l0, input logic [15:0] l1,
                             input logic [15:0] l2, input logic [15:0] l3,
                             input logic [15:0] h0, input logic [15:0] h1,
                             input logic [15:0] h2, input logic [15:0] h3);
        write_tap(REG_LOW_TAP0, l0);
        write_tap(REG_LOW_TAP1, l1);
        write_tap(REG_LOW_TAP2, l2);
        write_tap(REG_LOW_TAP3, l3);
        write_tap(REG_HIGH_TAP0, h0);
        write_tap(REG_HIGH_TAP1, h1);
        write_tap(REG_HIGH_TAP2, h2);
        write_tap(REG_HIGH_TAP3, h3);
    endtask

    // Mix of extremes, small values around zero and full-range values.
    function automatic logic [15:0] pick_value();
        int mode;
        mode = $urandom_range(99);
        if (mode < 10)
        begin
            case ($urandom_range(3))
                0:       return MAX_VAL;
                1:       return MIN_VAL;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        else if (mode < 30)
            return 16'($urandom_range(511)) - 16'd256;
        else
            return 16'($urandom);
    endfunction

    task automatic push_sample(input logic [15:0] value, input logic last);
        logic ok;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
        begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end
        while (!ok);
        items_sent++;
        if (last)
            lines_sent++;
    endtask

    task automatic send_line(input int len);
        for (int i = 0; i < len; i++)
            push_sample(pick_value(), i == len - 1);
    endtask

    // Waits for every expected pair, then lets in-flight samples settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending_pairs != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int start;
        int pick;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short lines of one, two and three samples.
        push_sample(MAX_VAL, 1'b1);
        push_sample(MIN_VAL, 1'b0);
        push_sample(MAX_VAL, 1'b1);
        push_sample(16'h0001, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(MIN_VAL, 1'b1);
        // Shortest full line with alternating extremes, then odd and even tails.
        for (int i = 0; i < 4; i++)
            push_sample((i % 2) ? MIN_VAL : MAX_VAL, i == 3);
        for (int i = 0; i < 5; i++)
            push_sample(MIN_VAL, i == 4);
        push_sample(MAX_VAL, 1'b0);
        push_sample(16'h0000, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0001, 1'b0);
        push_sample(MAX_VAL, 1'b0);
        push_sample(MIN_VAL, 1'b1);
        drain();

        // Every tap at the negative extreme makes the sums wrap past 18 bits.
        load_taps(MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL);
        for (int i = 0; i < 4; i++)
            push_sample(MIN_VAL, i == 3);
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: load_taps(MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL,
                             MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
                2: load_taps(MAX_VAL, MIN_VAL, MAX_VAL, MIN_VAL,
                             MIN_VAL, MAX_VAL, MIN_VAL, MAX_VAL);
                4: load_taps(-16'sd4240, 16'sd7345, 16'sd27411, 16'sd15826,
                             -16'sd15826, 16'sd27411, -16'sd7345, -16'sd4240);
                default: load_taps(pick_value(), pick_value(), pick_value(), pick_value(),
                                   pick_value(), pick_value(), pick_value(), pick_value());
            endcase
            steady = (phase == 3);
            start  = items_sent;
            if (phase == 1)
            begin
                // The output holds off while a long line keeps arriving.
                hold_pending = 1'b1;
                send_line(48);
            end
            while (items_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    len = $urandom_range(3, 1);
                else if (pick < 90)
                    len = $urandom_range(16, 4);
                else
                    len = $urandom_range(64, 17);
                send_line(len);
            end
            drain();
        end
        steady = 1'b0;

        $display("Sent %0d samples in %0d lines under %0d tap settings, with short lines,",
                 items_sent, lines_sent, NUM_PHASES + 2);
        $display("odd and even tails, wrapped sums and a %0d-cycle output hold-off; %0d pairs checked.",
                 HOLD_CYCLES, pairs_seen);
        if (mismatches == 0 && pending_pairs == 0)
            $display("Simulation PASSED");
        else
        begin
            if (pending_pairs != 0)
                $display("%0t: %0d expected pairs never arrived", $time, pending_pairs);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sym2dwt_pkg.sv
sv/sym2dwt_mac.sv
sv/sym2_dwt_analysis_line.sv
tb/sv/sym2_dwt_scoreboard.sv
tb/sv/tb_sym2_dwt_analysis_line.sv
